// ===== rtl/core/sio_command_frame_receiver_assert.svh =====
// Assertion macros for the command frame receiver.
`ifndef SIO_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define SIO_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SIO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SIO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sio_cfr_pkg.sv =====
// Shared types and constants of the command frame receiver.
`default_nettype none
package sio_cfr_pkg;

    localparam int SLOTS = 16;

    typedef logic [2:0]  cfg_index_t;
    typedef logic [63:0] cfg_data_t;
    typedef logic [1:0]  route_t;

    localparam cfg_index_t REG_ERROR_THRESHOLD  = 3'd0;
    localparam cfg_index_t REG_INTERCEPT_ENABLE = 3'd1;
    localparam cfg_index_t REG_DISK_ID          = 3'd2;
    localparam cfg_index_t REG_POLL_ID          = 3'd3;
    localparam cfg_index_t REG_SLOT_IDS_LOW     = 3'd4;
    localparam cfg_index_t REG_SLOT_IDS_HIGH    = 3'd5;
    localparam cfg_index_t REG_POLL_LISTEN_MASK = 3'd6;

    localparam route_t ROUTE_NONE      = 2'd0;
    localparam route_t ROUTE_INTERCEPT = 2'd1;
    localparam route_t ROUTE_POLL      = 2'd2;
    localparam route_t ROUTE_SLOTS     = 2'd3;

    localparam logic [2:0] CHECKSUM_POS = 3'd4;

    localparam logic [7:0] RESET_ERROR_THRESHOLD = 8'd2;
    localparam logic [7:0] RESET_DISK_ID         = 8'd49;
    localparam logic [7:0] RESET_POLL_ID         = 8'd79;

endpackage
`default_nettype wire

// ===== rtl/core/sio_cfr_if.sv =====
// Word channels of the command frame receiver: received bytes and frame results.
`default_nettype none
interface sio_cfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sio_cfr_result_if;
    logic        valid;
    logic        ready;
    logic        frame_good;
    logic [7:0]  device_byte;
    logic [7:0]  command_code;
    logic [15:0] aux_value;
    logic [1:0]  route;
    logic [15:0] slot_mask;
    logic        toggle_speed;
    logic        high_speed;

    modport source (output valid, output frame_good, output device_byte,
                    output command_code, output aux_value, output route,
                    output slot_mask, output toggle_speed, output high_speed,
                    input ready);
    modport sink (input valid, input frame_good, input device_byte,
                  input command_code, input aux_value, input route,
                  input slot_mask, input toggle_speed, input high_speed,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sio_command_frame_receiver.sv =====
// Command frame receiver: checksum, routing and bad-frame speed control.
//
// Takes one received byte per word on the byte channel and gives one result
// word after the fifth byte (checksum) of each frame. A byte is accepted in
// every cycle unless the output register stalls the input. A byte first lands
// in an input register and is then folded into the frame state; a checksum
// byte places its result in the output register when it is folded. The output
// register stalls the input only while a finished result is not taken and the
// next checksum byte is already waiting. Write configuration only while the
// block is idle.
`default_nettype none
module sio_command_frame_receiver (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    sio_cfr_byte_if.sink                 bytes,
    sio_cfr_result_if.source             result,
    input  wire logic                    cfg_we,
    input  wire sio_cfr_pkg::cfg_index_t cfg_index,
    input  wire sio_cfr_pkg::cfg_data_t  cfg_data
);
    import sio_cfr_pkg::*;

    logic [7:0]  error_threshold_reg;
    logic        intercept_enable_reg;
    logic [7:0]  disk_id_reg;
    logic [7:0]  poll_id_reg;
    logic [63:0] slot_ids_low_reg;
    logic [63:0] slot_ids_high_reg;
    logic [15:0] poll_listen_mask_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    logic [2:0]  byte_count_reg;
    logic [2:0]  byte_count_next;
    logic [7:0]  running_sum_reg;
    logic [7:0]  running_sum_next;
    logic [7:0]  frame_bytes_reg [4];
    logic [7:0]  bad_count_reg;
    logic [7:0]  bad_count_next;
    logic        speed_mode_reg;
    logic        speed_mode_next;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [7:0]  out_dev_reg;
    logic [7:0]  out_cmd_reg;
    logic [15:0] out_aux_reg;
    route_t      out_route_reg;
    logic [15:0] out_mask_reg;
    logic        out_toggle_reg;

    logic [2:0]  eff_count;
    logic        is_checksum;
    logic        out_free;
    logic        stage_fire;
    logic        result_load;
    logic [8:0]  sum_wide;
    logic        sum_ok;
    logic [7:0]  dev;
    logic [7:0]  bad_inc;
    logic        toggle;
    logic [15:0] occupied;
    logic [15:0] matched;
    logic [7:0]  slot_id;
    route_t      route;
    logic [15:0] mask;

    always_comb
    begin
        eff_count   = (in_start_reg || byte_count_reg > CHECKSUM_POS) ? 3'd0 : byte_count_reg;
        is_checksum = (eff_count == CHECKSUM_POS);
        out_free    = !out_valid_reg || result.ready;
        stage_fire  = in_valid_reg && (!is_checksum || out_free);
        result_load = stage_fire && is_checksum;
        sum_wide    = {1'b0, (eff_count == 3'd0) ? 8'd0 : running_sum_reg} + {1'b0, in_byte_reg};
    end

    assign bytes.ready = !in_valid_reg || stage_fire;

    always_comb
    begin
        occupied = '0;
        matched  = '0;
        dev      = frame_bytes_reg[0];
        for (int i = 0; i < 16; i++)
        begin
            slot_id = (i < 8) ? slot_ids_low_reg[(i % 8) * 8 +: 8]
                              : slot_ids_high_reg[(i % 8) * 8 +: 8];
            if (i < SLOTS && slot_id != 8'd0)
            begin
                occupied[i] = 1'b1;
                matched[i]  = (slot_id == dev);
            end
        end
    end

    always_comb
    begin
        sum_ok          = (running_sum_reg == in_byte_reg);
        route           = ROUTE_NONE;
        mask            = '0;
        bad_inc         = bad_count_reg + 8'd1;
        toggle          = 1'b0;
        bad_count_next  = bad_count_reg;
        speed_mode_next = speed_mode_reg;
        if (sum_ok)
        begin
            if (intercept_enable_reg && dev == disk_id_reg)
            begin
                route = ROUTE_INTERCEPT;
            end
            else if (dev == poll_id_reg)
            begin
                mask  = poll_listen_mask_reg & occupied;
                route = (mask != '0) ? ROUTE_POLL : ROUTE_NONE;
            end
            else
            begin
                mask  = matched;
                route = (mask != '0) ? ROUTE_SLOTS : ROUTE_NONE;
            end
        end
        else if (bad_inc == error_threshold_reg)
        begin
            toggle          = 1'b1;
            bad_count_next  = 8'd0;
            speed_mode_next = !speed_mode_reg;
        end
        else
        begin
            bad_count_next = bad_inc;
        end

        if (is_checksum)
        begin
            byte_count_next  = 3'd0;
            running_sum_next = 8'd0;
        end
        else
        begin
            byte_count_next  = eff_count + 3'd1;
            running_sum_next = sum_wide[7:0] + {7'd0, sum_wide[8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_threshold_reg  <= RESET_ERROR_THRESHOLD;
            intercept_enable_reg <= 1'b0;
            disk_id_reg          <= RESET_DISK_ID;
            poll_id_reg          <= RESET_POLL_ID;
            slot_ids_low_reg     <= '0;
            slot_ids_high_reg    <= '0;
            poll_listen_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ERROR_THRESHOLD:  error_threshold_reg  <= cfg_data[7:0];
                REG_INTERCEPT_ENABLE: intercept_enable_reg <= cfg_data[0];
                REG_DISK_ID:          disk_id_reg          <= cfg_data[7:0];
                REG_POLL_ID:          poll_id_reg          <= cfg_data[7:0];
                REG_SLOT_IDS_LOW:     slot_ids_low_reg     <= cfg_data;
                REG_SLOT_IDS_HIGH:    slot_ids_high_reg    <= cfg_data;
                REG_POLL_LISTEN_MASK: poll_listen_mask_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            byte_count_reg <= 3'd0;
            running_sum_reg <= 8'd0;
            bad_count_reg  <= 8'd0;
            speed_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (bytes.ready)
            begin
                in_valid_reg <= bytes.valid;
            end
            if (stage_fire)
            begin
                byte_count_reg  <= byte_count_next;
                running_sum_reg <= running_sum_next;
            end
            if (result_load)
            begin
                bad_count_reg  <= bad_count_next;
                speed_mode_reg <= speed_mode_next;
            end
            out_valid_reg <= result_load || (out_valid_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            in_byte_reg  <= bytes.rx_byte;
            in_start_reg <= bytes.frame_start;
        end
        if (stage_fire && !is_checksum)
        begin
            frame_bytes_reg[eff_count[1:0]] <= in_byte_reg;
        end
        if (result_load)
        begin
            out_ok_reg     <= sum_ok;
            out_dev_reg    <= dev;
            out_cmd_reg    <= frame_bytes_reg[1];
            out_aux_reg    <= {frame_bytes_reg[3], frame_bytes_reg[2]};
            out_route_reg  <= route;
            out_mask_reg   <= mask;
            out_toggle_reg <= toggle;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_good   = out_ok_reg;
    assign result.device_byte  = out_dev_reg;
    assign result.command_code = out_cmd_reg;
    assign result.aux_value    = out_aux_reg;
    assign result.route        = out_route_reg;
    assign result.slot_mask    = out_mask_reg;
    assign result.toggle_speed = out_toggle_reg;
    assign result.high_speed   = speed_mode_reg;

`include "sio_command_frame_receiver_assert.svh"

    `SIO_ASSERT_IMPL(a_count_range, 1'b1, byte_count_reg <= CHECKSUM_POS,
                     "byte count out of range")
    `SIO_ASSERT_IMPL(a_route_needs_ok, out_valid_reg && out_route_reg != ROUTE_NONE,
                     out_ok_reg, "routed bad frame")
    `SIO_ASSERT_IMPL(a_toggle_on_bad, out_valid_reg && out_toggle_reg,
                     !out_ok_reg && out_route_reg == ROUTE_NONE, "toggle on good frame")
    `SIO_ASSERT_NEXT(a_speed_hold, !result_load, $stable(speed_mode_reg),
                     "speed changed without frame")

endmodule
`default_nettype wire

// ===== dv/sio_command_frame_receiver_tb.sv =====
// Self-checking testbench for the command frame receiver: directed, random and stall traffic.
`timescale 1ns / 100ps

module sio_command_frame_receiver_tb;
    import sio_cfr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic        ok;
        logic [7:0]  dev;
        logic [7:0]  cmd;
        logic [15:0] aux;
        route_t      route;
        logic [15:0] slots;
        logic        toggle;
        logic        speed;
    } frame_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    sio_cfr_byte_if   byte_ch ();
    sio_cfr_result_if res_ch ();

    sio_command_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int src_idle = 13;
    int snk_idle = 84;
    int hold_left = 0;
    int err_count = 0;
    int cycle_count = 0;
    logic hold_req;

    frame_result_t pending_results[$];

    // register shadow
    logic [7:0]  thresh_reg;
    logic        icpt_reg;
    logic [7:0]  disk_reg;
    logic [7:0]  poll_reg;
    logic [7:0]  slot_id_reg [SLOTS];
    logic [15:0] listen_reg;

    // frame state
    logic [2:0] rx_count;
    logic [7:0] rx_sum;
    logic [7:0] rx_bytes [4];
    logic [7:0] bad_count;
    logic       speed_mode;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sio_command_frame_receiver_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [7:0] add_wrap(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic logic [7:0] good_checksum(input logic [7:0] d, input logic [7:0] c,
                                                 input logic [7:0] a1, input logic [7:0] a2);
        return add_wrap(add_wrap(add_wrap(d, c), a1), a2);
    endfunction

    task automatic fold_rx_byte(input logic [7:0] b, input logic start);
        frame_result_t r;
        logic [15:0]   occupied;
        logic [15:0]   hits;
        if (start || rx_count > CHECKSUM_POS)
        begin
            rx_count = '0;
            rx_sum = '0;
        end
        if (rx_count < CHECKSUM_POS)
        begin
            rx_bytes[rx_count[1:0]] = b;
            rx_sum = add_wrap(rx_sum, b);
            rx_count = rx_count + 3'd1;
        end
        else
        begin
            occupied = '0;
            hits = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_id_reg[i] != 8'd0)
                begin
                    occupied[i] = 1'b1;
                    hits[i] = (slot_id_reg[i] == rx_bytes[0]);
                end
            end
            r.ok = (rx_sum == b);
            r.dev = rx_bytes[0];
            r.cmd = rx_bytes[1];
            r.aux = {rx_bytes[3], rx_bytes[2]};
            r.route = ROUTE_NONE;
            r.slots = '0;
            r.toggle = 1'b0;
            if (r.ok)
            begin
                if (icpt_reg && r.dev == disk_reg)
                    r.route = ROUTE_INTERCEPT;
                else if (r.dev == poll_reg)
                begin
                    r.slots = listen_reg & occupied;
                    r.route = (r.slots != 16'd0) ? ROUTE_POLL : ROUTE_NONE;
                end
                else
                begin
                    r.slots = hits;
                    r.route = (r.slots != 16'd0) ? ROUTE_SLOTS : ROUTE_NONE;
                end
            end
            else
            begin
                bad_count = bad_count + 8'd1;
                if (bad_count == thresh_reg)
                begin
                    bad_count = '0;
                    speed_mode = ~speed_mode;
                    r.toggle = 1'b1;
                end
            end
            r.speed = speed_mode;
            pending_results.push_back(r);
            rx_count = '0;
            rx_sum = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (pending_results.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: result word with none pending, device %h", $realtime,
                         res_ch.device_byte);
            return;
        end
        want = pending_results.pop_front();
        compare_field("frame_good", 16'(want.ok), 16'(res_ch.frame_good));
        compare_field("device_byte", 16'(want.dev), 16'(res_ch.device_byte));
        compare_field("command_code", 16'(want.cmd), 16'(res_ch.command_code));
        compare_field("aux_value", want.aux, res_ch.aux_value);
        compare_field("route", 16'(want.route), 16'(res_ch.route));
        compare_field("slot_mask", want.slots, res_ch.slot_mask);
        compare_field("toggle_speed", 16'(want.toggle), 16'(res_ch.toggle_speed));
        compare_field("high_speed", 16'(want.speed), 16'(res_ch.high_speed));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            fold_rx_byte(byte_ch.rx_byte, byte_ch.frame_start);
        if (rst_n && res_ch.valid && res_ch.ready)
            check_result();
    end

    task automatic send_word(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < src_idle)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.rx_byte <= b;
        byte_ch.frame_start <= start;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] d, input logic [7:0] c, input logic [7:0] a1,
                              input logic [7:0] a2, input logic [7:0] ck, input logic start);
        send_word(d, start);
        send_word(c, 1'b0);
        send_word(a1, 1'b0);
        send_word(a2, 1'b0);
        send_word(ck, 1'b0);
    endtask

    task automatic send_bad_frame();
        logic [7:0] d;
        logic [7:0] c;
        logic [7:0] a1;
        logic [7:0] a2;
        d = 8'($urandom);
        c = 8'($urandom);
        a1 = 8'($urandom);
        a2 = 8'($urandom);
        send_frame(d, c, a1, a2, good_checksum(d, c, a1, a2) ^ 8'($urandom_range(1, 255)),
                   1'b1);
    endtask

    // drop valid, then wait for the block to drain
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_ERROR_THRESHOLD:  thresh_reg = val[7:0];
            REG_INTERCEPT_ENABLE: icpt_reg = val[0];
            REG_DISK_ID:          disk_reg = val[7:0];
            REG_POLL_ID:          poll_reg = val[7:0];
            REG_SLOT_IDS_LOW:
                for (int i = 0; i < 8; i++)
                    slot_id_reg[i] = val[8 * i +: 8];
            REG_SLOT_IDS_HIGH:
                for (int i = 0; i < 8; i++)
                    slot_id_reg[8 + i] = val[8 * i +: 8];
            REG_POLL_LISTEN_MASK: listen_reg = val[15:0];
            default: ;
        endcase
    endtask

    // mode 1: every register at its maximum, mode 2: at its minimum but the error threshold at 1, else random
    task automatic load_random_settings(input int mode);
        logic [7:0]  ids [16];
        logic [7:0]  pool [4];
        cfg_data_t   lo;
        cfg_data_t   hi;
        logic [7:0]  th;
        logic [7:0]  dk;
        logic [7:0]  pl;
        logic        ie;
        logic [15:0] lm;
        if (mode == 1)
        begin
            th = 8'hff;
            ie = 1'b1;
            dk = 8'hff;
            pl = 8'hff;
            lm = 16'hffff;
            foreach (ids[i])
                ids[i] = 8'hff;
        end
        else if (mode == 2)
        begin
            th = 8'd1;
            ie = 1'b0;
            dk = 8'd0;
            pl = 8'd0;
            lm = 16'h0000;
            foreach (ids[i])
                ids[i] = 8'd0;
        end
        else
        begin
            th = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 6));
            ie = 1'($urandom_range(1));
            dk = 8'($urandom);
            pl = 8'($urandom);
            lm = 16'($urandom);
            pool[0] = dk;
            pool[1] = pl;
            pool[2] = 8'($urandom);
            pool[3] = 8'($urandom);
            foreach (ids[i])
                ids[i] = ($urandom_range(9) < 3) ? 8'd0 : pool[2'($urandom_range(3))];
        end
        for (int i = 0; i < 8; i++)
        begin
            lo[8 * i +: 8] = ids[i];
            hi[8 * i +: 8] = ids[8 + i];
        end
        settle();
        write_reg(REG_ERROR_THRESHOLD, cfg_data_t'(th));
        write_reg(REG_INTERCEPT_ENABLE, cfg_data_t'(ie));
        write_reg(REG_DISK_ID, cfg_data_t'(dk));
        write_reg(REG_POLL_ID, cfg_data_t'(pl));
        write_reg(REG_SLOT_IDS_LOW, lo);
        write_reg(REG_SLOT_IDS_HIGH, hi);
        write_reg(REG_POLL_LISTEN_MASK, cfg_data_t'(lm));
    endtask

    task automatic random_traffic(input int n_items);
        int         sent;
        int         kind;
        int         len;
        bit         aligned;
        logic [7:0] d;
        logic [7:0] c;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] ck;
        sent = 0;
        aligned = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                case ($urandom_range(9))
                    0, 1, 2: d = slot_id_reg[4'($urandom_range(SLOTS - 1))];
                    3, 4:    d = poll_reg;
                    5:       d = disk_reg;
                    6:       d = 8'd0;
                    default: d = 8'($urandom);
                endcase
                c = 8'($urandom);
                a1 = 8'($urandom);
                a2 = 8'($urandom);
                ck = good_checksum(d, c, a1, a2);
                if ($urandom_range(99) < 25)
                    ck = ck ^ 8'($urandom_range(1, 255));
                send_frame(d, c, a1, a2, ck, !(aligned && $urandom_range(4) == 0));
                aligned = 1;
                sent += 5;
            end
            else if (kind < 93)
            begin
                len = $urandom_range(1, 4);
                send_word(8'($urandom), 1'b1);
                for (int i = 1; i < len; i++)
                    send_word(8'($urandom), 1'b0);
                aligned = 0;
                sent += len;
            end
            else
            begin
                send_word(8'($urandom), 1'($urandom_range(1)));
                aligned = 0;
                sent++;
            end
        end
    endtask

    task automatic test_directed_frames();
        // reset settings: no intercept, no slots
        send_frame(8'h31, 8'h00, 8'h00, 8'h00, good_checksum(8'h31, 8'h00, 8'h00, 8'h00), 1'b1);
        settle();
        write_reg(REG_ERROR_THRESHOLD, 64'd1);
        write_reg(REG_INTERCEPT_ENABLE, 64'd1);
        write_reg(REG_DISK_ID, 64'h31);
        write_reg(REG_POLL_ID, 64'h4f);
        write_reg(REG_SLOT_IDS_LOW, 64'h0000_0000_0000_524f);
        write_reg(REG_SLOT_IDS_HIGH, 64'h5200_0000_0000_0031);
        write_reg(REG_POLL_LISTEN_MASK, 64'h8007);
        send_frame(8'h31, 8'hff, 8'hff, 8'hff, good_checksum(8'h31, 8'hff, 8'hff, 8'hff), 1'b1);
        send_frame(8'h4f, 8'h00, 8'h00, 8'h00, good_checksum(8'h4f, 8'h00, 8'h00, 8'h00), 1'b1);
        send_word(8'h52, 1'b1);
        send_frame(8'h52, 8'h7e, 8'h34, 8'h12, good_checksum(8'h52, 8'h7e, 8'h34, 8'h12), 1'b1);
        send_frame(8'h52, 8'h80, 8'hff, 8'h00, good_checksum(8'h52, 8'h80, 8'hff, 8'h00), 1'b0);
        send_frame(8'haa, 8'h55, 8'hc3, 8'h3c, ~good_checksum(8'haa, 8'h55, 8'hc3, 8'h3c), 1'b1);
        settle();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int mode);
        src_idle = src_pct;
        snk_idle = snk_pct;
        load_random_settings(mode);
        random_traffic(105);
        load_random_settings(0);
        random_traffic(105);
        settle();
    endtask

    task automatic test_backpressure();
        src_idle = 0;
        snk_idle = 0;
        load_random_settings(0);
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
        for (int i = 0; i < 8; i++)
            send_bad_frame();
        settle();
    endtask

    task automatic test_threshold_changes();
        src_idle = 0;
        snk_idle = 0;
        write_reg(REG_ERROR_THRESHOLD, 64'd255);
        for (int i = 0; i < 3; i++)
            send_bad_frame();
        settle();
        write_reg(REG_ERROR_THRESHOLD, 64'd0);
        for (int i = 0; i < 5; i++)
            send_bad_frame();
        settle();
        write_reg(REG_ERROR_THRESHOLD, 64'd4);
        for (int i = 0; i < 3; i++)
            send_bad_frame();
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = '0;
        byte_ch.frame_start = 1'b0;
        res_ch.ready = 1'b0;
        thresh_reg = RESET_ERROR_THRESHOLD;
        icpt_reg = 1'b0;
        disk_reg = RESET_DISK_ID;
        poll_reg = RESET_POLL_ID;
        listen_reg = '0;
        foreach (slot_id_reg[i])
            slot_id_reg[i] = '0;
        rx_count = '0;
        rx_sum = '0;
        bad_count = '0;
        speed_mode = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_random_traffic(13, 84, 1);
        test_random_traffic(84, 13, 2);
        test_random_traffic(0, 0, 0);
        test_backpressure();
        test_threshold_changes();

        settle();
        err_count += pending_results.size();
        if (err_count == 0)
            $display("sio_command_frame_receiver_tb: done, clean");
        else
            $display("sio_command_frame_receiver_tb: done, errors");
        $finish;
    end

endmodule
